// File: design/mtdc_pkg.sv
// ----------------------------------------------------------------------------
// mtdc_pkg
// Shared types, codes and constants of the multi-tap delay with crossfade.
// ----------------------------------------------------------------------------
package mtdc_pkg;

   // ring and taps
   localparam int RING_DEPTH = 16384;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int TAP_COUNT  = 10;
   localparam int TAP_W      = 4;
   localparam int DELAY_W    = 14;
   localparam int FADE_W     = 16;
   localparam int SAMPLE_W   = 16;

   // gains, unsigned Q2.16
   localparam int GAIN_W = 18;
   localparam logic [GAIN_W-1:0] GAIN_ONE      = 18'd65536;
   localparam logic [GAIN_W-1:0] GAIN_START_IN = 18'd655;
   localparam logic [GAIN_W-1:0] GAIN_MAX      = 18'd262143;

   // configuration registers
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEZE      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_LENGTH = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_DECAY  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_GROWTH = 4'd3;
   localparam logic [15:0] FADE_LENGTH_RST = 16'd4410;
   localparam logic [16:0] FADE_DECAY_RST  = 17'd65467;
   localparam logic [17:0] FADE_GROWTH_RST = 18'd65605;

   // opcodes
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_SET_TAP = 2'd1;
   localparam logic [1:0] OP_DISABLE = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]          opcode;
      logic signed [15:0]  sample_in;
      logic [3:0]          tap_index;
      logic [15:0]         delay_samples;
   } req_word_type;

   typedef struct packed {
      logic [3:0]          tap_number;
      logic signed [15:0]  sample_out;
      logic [13:0]         tap_delay;
      logic                is_reply;
      logic                last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic latch_item;
      logic ring_write;
      logic tap_clear;
      logic tap_inc;
      logic read_issue;
      logic mult_en;
      logic tap_emit;
      logic set_emit;
      logic disable_tap;
      logic advance_wp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic cur_active;
      logic more_active;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: design/mtdc_ctrl.sv
// ----------------------------------------------------------------------------
// mtdc_ctrl
// Sequencer: ring clearing, item decode and the walk over the taps.
// ----------------------------------------------------------------------------
module mtdc_ctrl
   import mtdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_opcode,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_WRITE = 4'd2;
   localparam logic [3:0] ST_SCAN  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_MULT  = 4'd5;
   localparam logic [3:0] ST_EMIT  = 4'd6;
   localparam logic [3:0] ST_ADV   = 4'd7;
   localparam logic [3:0] ST_SET   = 4'd8;
   localparam logic [3:0] ST_DIS   = 4'd9;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               case (req_opcode)
                  OP_SAMPLE:  state_in = ST_WRITE;
                  OP_SET_TAP: state_in = ST_SET;
                  OP_DISABLE: state_in = ST_DIS;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.ring_write = 1'b1;
            cmd.tap_clear  = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.cur_active) state_in = ST_READ;
            else if (sts.more_active) cmd.tap_inc = 1'b1;
            else state_in = ST_ADV;
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_en = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.tap_emit = 1'b1;
               if (sts.more_active) begin
                  cmd.tap_inc = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            cmd.advance_wp = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SET: begin
            if (sts.rsp_free) begin
               cmd.set_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIS: begin
            cmd.disable_tap = 1'b1;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

// File: design/mtdc_dp.sv
// ----------------------------------------------------------------------------
// mtdc_dp
// Datapath: ring memory, tap state, gain and crossfade arithmetic, output word.
// ----------------------------------------------------------------------------
module mtdc_dp
   import mtdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         sts,
   input  req_word_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data
);

   // configuration
   logic        freeze_ff;
   logic [15:0] fade_len_ff;
   logic [16:0] fade_decay_ff;
   logic [17:0] fade_growth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freeze_ff      <= 1'b0;
         fade_len_ff    <= FADE_LENGTH_RST;
         fade_decay_ff  <= FADE_DECAY_RST;
         fade_growth_ff <= FADE_GROWTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FREEZE:      freeze_ff      <= csr_data[0];
            CSR_FADE_LENGTH: fade_len_ff    <= csr_data[15:0];
            CSR_FADE_DECAY:  fade_decay_ff  <= csr_data[16:0];
            CSR_FADE_GROWTH: fade_growth_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // latched item
   logic signed [15:0]  sample_ff;
   logic [TAP_W-1:0]    tix_ff;
   logic [DELAY_W-1:0]  dly_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         sample_ff <= req_data.sample_in;
         tix_ff    <= req_data.tap_index;
         // clamp to ring length minus one
         dly_ff    <= (req_data.delay_samples > 16'(RING_DEPTH - 1))
                      ? DELAY_W'(RING_DEPTH - 1) : req_data.delay_samples[DELAY_W-1:0];
      end
   end

   // positions
   logic [RING_AW-1:0] wp_ff, clr_ff;
   logic [TAP_W-1:0]   tcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         clr_ff  <= '0;
         tcnt_ff <= '0;
      end else begin
         if (cmd.advance_wp) wp_ff <= wp_ff + 1'b1;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.tap_clear) tcnt_ff <= '0;
         else if (cmd.tap_inc) tcnt_ff <= tcnt_ff + 1'b1;
      end
   end

   // tap state
   logic [TAP_COUNT-1:0] act_ff;
   logic [DELAY_W-1:0]   now_ff    [TAP_COUNT];
   logic [DELAY_W-1:0]   tgt_ff    [TAP_COUNT];
   logic [DELAY_W-1:0]   want_ff   [TAP_COUNT];
   logic [FADE_W-1:0]    left_ff   [TAP_COUNT];
   logic [GAIN_W-1:0]    gout_ff   [TAP_COUNT];
   logic [GAIN_W-1:0]    gin_ff    [TAP_COUNT];

   // active taps above the current one
   logic [TAP_COUNT-1:0] above;
   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         above[i] = (TAP_W'(i) > tcnt_ff) && act_ff[i];
      end
   end

   assign sts.clear_last  = (clr_ff == {RING_AW{1'b1}});
   assign sts.cur_active  = act_ff[tcnt_ff];
   assign sts.more_active = |above;

   // ring memory: one write and two reads a cycle
   logic [SAMPLE_W-1:0] ring [RING_DEPTH];
   logic [SAMPLE_W-1:0] rd_now_ff, rd_tgt_ff;
   logic [RING_AW-1:0]  addr_now, addr_tgt;

   assign addr_now = wp_ff - now_ff[tcnt_ff];
   assign addr_tgt = wp_ff - tgt_ff[tcnt_ff];

   always_ff @(posedge clock) begin
      if (cmd.clear_step) ring[clr_ff] <= '0;
      else if (cmd.ring_write && !freeze_ff) ring[wp_ff] <= sample_ff;
      if (cmd.read_issue) begin
         rd_now_ff <= ring[addr_now];
         rd_tgt_ff <= ring[addr_tgt];
      end
   end

   // gain step: multiply, drop 16 bits, saturate
   logic [34:0]       gout_prod;
   logic [35:0]       gin_prod;
   logic [GAIN_W-1:0] gout_new_ff, gin_new_ff;

   assign gout_prod = gout_ff[tcnt_ff] * fade_decay_ff;
   assign gin_prod  = gin_ff[tcnt_ff] * fade_growth_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         gout_new_ff <= gout_prod[34] ? GAIN_MAX : gout_prod[33:16];
         gin_new_ff  <= (|gin_prod[35:34]) ? GAIN_MAX : gin_prod[33:16];
      end
   end

   // sample times gain
   logic signed [34:0] pa_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (cmd.mult_en) begin
         pa_ff <= $signed(rd_now_ff) * $signed({1'b0, gout_new_ff});
         pb_ff <= $signed(rd_tgt_ff) * $signed({1'b0, gin_new_ff});
      end
   end

   // divide by 65536 toward zero, sum and saturate
   logic signed [34:0] pa_adj, pb_adj;
   logic signed [18:0] qa, qb;
   logic signed [19:0] mix_sum;
   logic signed [15:0] mix_sat;

   always_comb begin
      pa_adj  = pa_ff[34] ? pa_ff + 35'sd65535 : pa_ff;
      pb_adj  = pb_ff[34] ? pb_ff + 35'sd65535 : pb_ff;
      qa      = pa_adj[34:16];
      qb      = pb_adj[34:16];
      mix_sum = 20'(qa) + 20'(qb);
      if (mix_sum > 20'sd32767) mix_sat = 16'sh7fff;
      else if (mix_sum < -20'sd32768) mix_sat = 16'sh8000;
      else mix_sat = mix_sum[15:0];
   end

   // tap step outcome
   logic               fading, fade_end, chain;
   logic [FADE_W-1:0]  left_dec;
   logic [DELAY_W-1:0] delay_after;

   always_comb begin
      fading   = (left_ff[tcnt_ff] != '0);
      left_dec = left_ff[tcnt_ff] - 1'b1;
      fade_end = fading && (left_dec == '0);
      chain    = fade_end && (want_ff[tcnt_ff] != tgt_ff[tcnt_ff]);
      if (chain && fade_len_ff == '0) delay_after = want_ff[tcnt_ff];
      else if (fade_end) delay_after = tgt_ff[tcnt_ff];
      else delay_after = now_ff[tcnt_ff];
   end

   // set-tap outcome
   logic               set_ok;
   logic [DELAY_W-1:0] set_reply;

   always_comb begin
      set_ok = (tix_ff < TAP_W'(TAP_COUNT));
      if (!set_ok) set_reply = '0;
      else if (!act_ff[tix_ff] || (left_ff[tix_ff] == '0 && fade_len_ff == '0))
         set_reply = dly_ff;
      else set_reply = now_ff[tix_ff];
   end

   // tap state update
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         for (int i = 0; i < TAP_COUNT; i++) begin
            now_ff[i]  <= '0;
            tgt_ff[i]  <= '0;
            want_ff[i] <= '0;
            left_ff[i] <= '0;
            gout_ff[i] <= '0;
            gin_ff[i]  <= '0;
         end
      end else begin
         if (cmd.tap_emit && fading) begin
            gout_ff[tcnt_ff] <= gout_new_ff;
            gin_ff[tcnt_ff]  <= gin_new_ff;
            left_ff[tcnt_ff] <= left_dec;
            if (fade_end) now_ff[tcnt_ff] <= delay_after;
            if (chain) begin
               tgt_ff[tcnt_ff] <= want_ff[tcnt_ff];
               if (fade_len_ff != '0) begin
                  left_ff[tcnt_ff] <= fade_len_ff;
                  gout_ff[tcnt_ff] <= GAIN_ONE;
                  gin_ff[tcnt_ff]  <= GAIN_START_IN;
               end
            end
         end
         if (cmd.set_emit && set_ok) begin
            want_ff[tix_ff] <= dly_ff;
            if (!act_ff[tix_ff]) begin
               act_ff[tix_ff]  <= 1'b1;
               now_ff[tix_ff]  <= dly_ff;
               tgt_ff[tix_ff]  <= dly_ff;
               left_ff[tix_ff] <= '0;
            end else if (left_ff[tix_ff] == '0) begin
               // start a fade, or switch at once when the length is zero
               tgt_ff[tix_ff] <= dly_ff;
               if (fade_len_ff == '0) begin
                  now_ff[tix_ff] <= dly_ff;
               end else begin
                  left_ff[tix_ff] <= fade_len_ff;
                  gout_ff[tix_ff] <= GAIN_ONE;
                  gin_ff[tix_ff]  <= GAIN_START_IN;
               end
            end
         end
         if (cmd.disable_tap && set_ok) act_ff[tix_ff] <= 1'b0;
      end
   end

   // output word register
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.tap_emit || cmd.set_emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_emit) begin
         rsp_data_ff.tap_number <= tcnt_ff;
         rsp_data_ff.sample_out <= fading ? mix_sat : $signed(rd_now_ff);
         rsp_data_ff.tap_delay  <= delay_after;
         rsp_data_ff.is_reply   <= 1'b0;
         rsp_data_ff.last       <= !sts.more_active;
      end else if (cmd.set_emit) begin
         rsp_data_ff.tap_number <= tix_ff;
         rsp_data_ff.sample_out <= '0;
         rsp_data_ff.tap_delay  <= set_reply;
         rsp_data_ff.is_reply   <= 1'b1;
         rsp_data_ff.last       <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/multi_tap_delay_crossfade.sv
// ----------------------------------------------------------------------------
// multi_tap_delay_crossfade
// Ring-buffer delay line with up to ten taps and exponential crossfades.
// ----------------------------------------------------------------------------
// Input words (req_) carry an opcode: audio sample, set tap delay, disable
// tap. Result words (rsp_) carry one delayed sample per active tap, in tap
// order, or one reply for a set-tap command; last marks the final word of an
// input word. Registers are written through csr_; the user must write them
// only while the block is idle; the block itself does not enforce this.
// After reset a clearing pass zeroes the ring, one entry a cycle, and
// req_ready stays low during it. Then tap state is all inactive.
// One input word is worked on at a time. For a sample the walk visits each
// tap up to the last active one; an active tap goes through ring read with
// gain step, sample multiply and output load. The taps use the shared
// multipliers one after another.
// The output register lets the next word be taken while a result waits. If
// rsp_ready is low the walk holds at the output load until the register
// frees; nothing is lost.
// ----------------------------------------------------------------------------
module multi_tap_delay_crossfade
   import mtdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequencer
   mtdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   mtdc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ready only while nothing is being emitted
   a_ready_no_emit: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.tap_emit && !cmd.set_emit)
      else $error("input ready while emitting");

   // a stalled result word holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result word changed while stalled");

   // command replies carry a zero sample and close their input word
   a_reply_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_reply) |-> (rsp_data.last && rsp_data.sample_out == '0))
      else $error("malformed command reply");

endmodule
